// File: rtl/wis_pkg.sv
// ----------------------------------------------------------------------------
// wis_pkg: shared types and constants
// Opcodes, status codes, sizing constants and the stack shift control used
// by the i32 stack execution unit and its operand cell chain.
// ----------------------------------------------------------------------------
package wis_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int LOCAL_SLOTS = 16;
    localparam int LABEL_DEPTH = 16;

    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int LOC_W   = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;
    localparam int LVL_W   = $clog2(LABEL_DEPTH);
    localparam int WORD_W  = 32;
    localparam int OFF_W   = 16;
    localparam int COUNT_W = 7;
    localparam int LCNT_W  = 5;

    localparam logic [WORD_W-1:0] BLOCK_TYPE_EMPTY = 32'h0000_0040;

    typedef enum logic [7:0] {
        OP_BLOCK     = 8'h02,
        OP_LOOP      = 8'h03,
        OP_END       = 8'h0B,
        OP_BR        = 8'h0C,
        OP_BR_IF     = 8'h0D,
        OP_DROP      = 8'h1A,
        OP_SELECT    = 8'h1B,
        OP_LOCAL_GET = 8'h20,
        OP_LOCAL_SET = 8'h21,
        OP_LOCAL_TEE = 8'h22,
        OP_I32_CONST = 8'h41,
        OP_I32_EQZ   = 8'h45,
        OP_I32_NE    = 8'h47,
        OP_I32_LT_S  = 8'h48,
        OP_I32_GT_S  = 8'h4A,
        OP_I32_GE_S  = 8'h4E,
        OP_I32_ADD   = 8'h6A,
        OP_I32_AND   = 8'h71
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_UNDER  = 3'd1,
        ST_OVER   = 3'd2,
        ST_LOCAL  = 3'd3,
        ST_OPCODE = 3'd4,
        ST_BRANCH = 3'd5,
        ST_ENDED  = 3'd6
    } t_status;

    // what a cell loads this cycle
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_LOAD = 2'd1,   // from the cell above (new value for the top cell)
        SH_POP1 = 2'd2,   // from the cell one below
        SH_POP2 = 2'd3    // from the cell two below
    } t_shift;

    typedef struct packed {
        t_shift top_mode;
        t_shift rest_mode;
    } t_stack_ctl;

endpackage

// File: rtl/wis_cell.sv
// ----------------------------------------------------------------------------
// wis_cell: one operand stack entry
// Holds one 32-bit word and reloads it from a neighbor or keeps it.
// ----------------------------------------------------------------------------
module wis_cell
    import wis_pkg::*;
(
    input  logic              i_clk,
    input  t_shift            i_mode,
    input  logic [WORD_W-1:0] i_from_up,
    input  logic [WORD_W-1:0] i_from_dn1,
    input  logic [WORD_W-1:0] i_from_dn2,
    output logic [WORD_W-1:0] o_value
);

    logic [WORD_W-1:0] r_value;
    logic [WORD_W-1:0] n_value;

    always_comb begin
        case (i_mode)
            SH_LOAD: n_value = i_from_up;
            SH_POP1: n_value = i_from_dn1;
            SH_POP2: n_value = i_from_dn2;
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// File: rtl/wis_stack.sv
// ----------------------------------------------------------------------------
// wis_stack: operand stack as a chain of cells
// Cell 0 is the top of stack. Push shifts the chain down, pops shift it up
// by one or two; the top three words are exposed to the execute logic.
// ----------------------------------------------------------------------------
module wis_stack
    import wis_pkg::*;
(
    input  logic              i_clk,
    input  t_stack_ctl        i_ctl,
    input  logic [WORD_W-1:0] i_new_top,
    output logic [WORD_W-1:0] o_top0,
    output logic [WORD_W-1:0] o_top1,
    output logic [WORD_W-1:0] o_top2
);

    logic [WORD_W-1:0] w_value [STACK_DEPTH];

    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        logic [WORD_W-1:0] w_up;
        logic [WORD_W-1:0] w_dn1;
        logic [WORD_W-1:0] w_dn2;
        t_shift            w_mode;

        if (gi == 0) begin : g_top
            assign w_up   = i_new_top;
            assign w_mode = i_ctl.top_mode;
        end else begin : g_rest
            assign w_up   = w_value[gi-1];
            assign w_mode = i_ctl.rest_mode;
        end

        // entries past the bottom are never read back
        if (gi + 1 < STACK_DEPTH) begin : g_dn1
            assign w_dn1 = w_value[gi+1];
        end else begin : g_dn1_end
            assign w_dn1 = '0;
        end

        if (gi + 2 < STACK_DEPTH) begin : g_dn2
            assign w_dn2 = w_value[gi+2];
        end else begin : g_dn2_end
            assign w_dn2 = '0;
        end

        wis_cell u_cell (
            .i_clk      (i_clk),
            .i_mode     (w_mode),
            .i_from_up  (w_up),
            .i_from_dn1 (w_dn1),
            .i_from_dn2 (w_dn2),
            .o_value    (w_value[gi])
        );
    end

    assign o_top0 = w_value[0];
    assign o_top1 = w_value[1];
    assign o_top2 = w_value[2];

endmodule

// File: rtl/wasm_i32_stack_execution_unit.sv
// Each accepted input beat's result beat is registered and appears in the cycle after acceptance.
// Throughput: 1 instruction per cycle while the result channel is not stalled; the operand cell chain, locals and
// label registers all update in the accept cycle, so the next beat sees them.
// The output register lets a new beat in while the previous result drains.
// Reset (i_rst_n low, synchronous): stack pointer, nesting level, local
// count, locals and labels clear; stack words stay undefined until pushed.
// ----------------------------------------------------------------------------
// wasm_i32_stack_execution_unit: decoded WebAssembly i32 instruction executor
// One instruction per beat on a cell-chain operand stack with locals and a
// label stack, one result beat per instruction.
// ----------------------------------------------------------------------------
module wasm_i32_stack_execution_unit
    import wis_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [LCNT_W-1:0]          i_cfg_data,
    // instruction channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_command,
    input  logic signed [WORD_W-1:0]   i_immediate,
    input  logic [OFF_W-1:0]           i_next_offset,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [2:0]                 o_status,
    output logic                       o_jump,
    output logic [OFF_W-1:0]           o_jump_offset,
    output logic signed [WORD_W-1:0]   o_top_value,
    output logic [COUNT_W-1:0]         o_stack_count
);

    logic [LCNT_W-1:0] r_local_count;
    logic [SP_W-1:0]   r_sp;
    logic [SP_W-1:0]   n_sp;
    logic [LVL_W-1:0]  r_level;
    logic [LVL_W-1:0]  n_level;
    logic [WORD_W-1:0] r_locals [LOCAL_SLOTS];
    logic [OFF_W-1:0]  r_labels [LABEL_DEPTH];

    logic               r_out_valid;
    logic [2:0]         r_out_status;
    logic               r_out_jump;
    logic [OFF_W-1:0]   r_out_joff;
    logic [WORD_W-1:0]  r_out_top;
    logic [COUNT_W-1:0] r_out_count;

    logic               w_accept;
    logic [WORD_W-1:0]  w_imm;
    logic [WORD_W-1:0]  w_top0;
    logic [WORD_W-1:0]  w_top1;
    logic [WORD_W-1:0]  w_top2;
    logic [WORD_W-1:0]  w_alu;
    logic [WORD_W-1:0]  w_local_rd;
    logic [OFF_W-1:0]   w_label_rd;
    logic [LOC_W-1:0]   w_loc_idx;
    logic               w_loc_ok;
    logic               w_stack_full;

    t_status            n_status;
    logic               n_jump;
    logic [OFF_W-1:0]   n_joff;
    logic [WORD_W-1:0]  n_new_top;
    logic [WORD_W-1:0]  n_top;
    t_stack_ctl         n_ctl;
    t_stack_ctl         w_ctl;
    logic               n_loc_we;
    logic               n_lbl_we;

    assign w_accept     = i_in_valid & ~o_in_stall;
    assign o_in_stall   = r_out_valid & i_out_stall;
    assign w_imm        = $unsigned(i_immediate);
    assign w_loc_idx    = w_imm[LOC_W-1:0];
    assign w_loc_ok     = (w_imm < WORD_W'(r_local_count)) &&
                          (w_imm < WORD_W'(LOCAL_SLOTS));
    assign w_local_rd   = r_locals[w_loc_idx];
    assign w_label_rd   = r_labels[r_level];
    assign w_stack_full = (r_sp >= SP_W'(STACK_DEPTH));

    wis_stack u_stack (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_new_top (n_new_top),
        .o_top0    (w_top0),
        .o_top1    (w_top1),
        .o_top2    (w_top2)
    );

    // binary ops: a is below, b on top
    always_comb begin
        case (t_opcode'(i_command))
            OP_I32_NE:   w_alu = WORD_W'(w_top1 != w_top0);
            OP_I32_LT_S: w_alu = WORD_W'($signed(w_top1) < $signed(w_top0));
            OP_I32_GT_S: w_alu = WORD_W'($signed(w_top1) > $signed(w_top0));
            OP_I32_GE_S: w_alu = WORD_W'($signed(w_top1) >= $signed(w_top0));
            OP_I32_ADD:  w_alu = w_top1 + w_top0;
            default:     w_alu = w_top1 & w_top0;
        endcase
    end

    always_comb begin
        n_status  = ST_OK;
        n_jump    = 1'b0;
        n_joff    = '0;
        n_sp      = r_sp;
        n_level   = r_level;
        n_new_top = '0;
        n_top     = w_top0;
        n_ctl     = '{top_mode: SH_HOLD, rest_mode: SH_HOLD};
        n_loc_we  = 1'b0;
        n_lbl_we  = 1'b0;
        case (t_opcode'(i_command))
            OP_BLOCK, OP_LOOP: begin
                if (w_imm != BLOCK_TYPE_EMPTY) begin
                    n_status = ST_BRANCH;
                end else if (r_level >= LVL_W'(LABEL_DEPTH - 1)) begin
                    n_status = ST_OVER;
                end else begin
                    n_level  = r_level + 1'b1;
                    n_lbl_we = (t_opcode'(i_command) == OP_LOOP);
                end
            end
            OP_END: begin
                if (r_level == '0) begin
                    n_status = ST_ENDED;
                end else begin
                    n_level = r_level - 1'b1;
                end
            end
            OP_BR: begin
                if (w_imm != '0 || r_level == '0) begin
                    n_status = ST_BRANCH;
                end else begin
                    n_jump = 1'b1;
                    n_joff = w_label_rd;
                end
            end
            OP_BR_IF: begin
                if (r_sp < SP_W'(1)) begin
                    n_status = ST_UNDER;
                end else if (w_top0 == '0) begin
                    n_sp  = r_sp - 1'b1;
                    n_top = w_top1;
                    n_ctl = '{top_mode: SH_POP1, rest_mode: SH_POP1};
                end else if (w_imm != '0 || r_level == '0) begin
                    // condition stays on the stack
                    n_status = ST_BRANCH;
                end else begin
                    n_sp   = r_sp - 1'b1;
                    n_top  = w_top1;
                    n_ctl  = '{top_mode: SH_POP1, rest_mode: SH_POP1};
                    n_jump = 1'b1;
                    n_joff = w_label_rd;
                end
            end
            OP_DROP: begin
                if (r_sp < SP_W'(1)) begin
                    n_status = ST_UNDER;
                end else begin
                    n_sp  = r_sp - 1'b1;
                    n_top = w_top1;
                    n_ctl = '{top_mode: SH_POP1, rest_mode: SH_POP1};
                end
            end
            OP_SELECT: begin
                if (r_sp < SP_W'(3)) begin
                    n_status = ST_UNDER;
                end else begin
                    n_new_top = (w_top0 != '0) ? w_top1 : w_top2;
                    n_top     = n_new_top;
                    n_sp      = r_sp - SP_W'(2);
                    n_ctl     = '{top_mode: SH_LOAD, rest_mode: SH_POP2};
                end
            end
            OP_LOCAL_GET: begin
                if (!w_loc_ok) begin
                    n_status = ST_LOCAL;
                end else if (w_stack_full) begin
                    n_status = ST_OVER;
                end else begin
                    n_new_top = w_local_rd;
                    n_top     = n_new_top;
                    n_sp      = r_sp + 1'b1;
                    n_ctl     = '{top_mode: SH_LOAD, rest_mode: SH_LOAD};
                end
            end
            OP_LOCAL_SET, OP_LOCAL_TEE: begin
                if (!w_loc_ok) begin
                    n_status = ST_LOCAL;
                end else if (r_sp < SP_W'(1)) begin
                    n_status = ST_UNDER;
                end else begin
                    n_loc_we = 1'b1;
                    if (t_opcode'(i_command) == OP_LOCAL_SET) begin
                        n_sp  = r_sp - 1'b1;
                        n_top = w_top1;
                        n_ctl = '{top_mode: SH_POP1, rest_mode: SH_POP1};
                    end
                end
            end
            OP_I32_CONST: begin
                if (w_stack_full) begin
                    n_status = ST_OVER;
                end else begin
                    n_new_top = w_imm;
                    n_top     = n_new_top;
                    n_sp      = r_sp + 1'b1;
                    n_ctl     = '{top_mode: SH_LOAD, rest_mode: SH_LOAD};
                end
            end
            OP_I32_EQZ: begin
                if (r_sp < SP_W'(1)) begin
                    n_status = ST_UNDER;
                end else begin
                    n_new_top = WORD_W'(w_top0 == '0);
                    n_top     = n_new_top;
                    n_ctl     = '{top_mode: SH_LOAD, rest_mode: SH_HOLD};
                end
            end
            OP_I32_NE, OP_I32_LT_S, OP_I32_GT_S, OP_I32_GE_S,
            OP_I32_ADD, OP_I32_AND: begin
                if (r_sp < SP_W'(2)) begin
                    n_status = ST_UNDER;
                end else begin
                    n_new_top = w_alu;
                    n_top     = n_new_top;
                    n_sp      = r_sp - 1'b1;
                    n_ctl     = '{top_mode: SH_LOAD, rest_mode: SH_POP1};
                end
            end
            default: begin
                n_status = ST_OPCODE;
            end
        endcase
    end

    assign w_ctl = w_accept ? n_ctl : t_stack_ctl'{top_mode: SH_HOLD, rest_mode: SH_HOLD};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_count <= '0;
        end else if (i_cfg_we) begin
            r_local_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp    <= '0;
            r_level <= '0;
            for (int i = 0; i < LOCAL_SLOTS; i++) begin
                r_locals[i] <= '0;
            end
            for (int i = 0; i < LABEL_DEPTH; i++) begin
                r_labels[i] <= '0;
            end
        end else if (w_accept) begin
            r_sp    <= n_sp;
            r_level <= n_level;
            if (n_loc_we) begin
                r_locals[w_loc_idx] <= w_top0;
            end
            if (n_lbl_we) begin
                r_labels[n_level] <= i_next_offset;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_status <= n_status;
            r_out_jump   <= n_jump;
            r_out_joff   <= n_joff;
            r_out_top    <= (n_sp == '0) ? '0 : n_top;
            r_out_count  <= COUNT_W'(n_sp);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_jump        = r_out_jump;
    assign o_jump_offset = r_out_joff;
    assign o_top_value   = $signed(r_out_top);
    assign o_stack_count = r_out_count;

endmodule

// File: rtl/wis_checker.sv
// ----------------------------------------------------------------------------
// wis_checker: port-level checks for the stack execution unit
// Watches the result channel for consistency of status, jump and stack view.
// ----------------------------------------------------------------------------
module wis_checker
    import wis_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     o_out_valid,
    input  logic                     i_out_stall,
    input  logic [2:0]               o_status,
    input  logic                     o_jump,
    input  logic [OFF_W-1:0]         o_jump_offset,
    input  logic signed [WORD_W-1:0] o_top_value,
    input  logic [COUNT_W-1:0]       o_stack_count
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present after reset");

    // a jump only comes with an ok status, and no jump carries no offset
    a_jump_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_jump) |-> (o_status == ST_OK))
        else $error("jump reported with an error status");

    a_no_jump_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_jump) |-> (o_jump_offset == '0))
        else $error("offset set without jump");

    // an empty stack shows a zero top
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stack_count == '0) |-> (o_top_value == '0))
        else $error("nonzero top on empty stack");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_top_value) &&
             $stable(o_stack_count)))
        else $error("stalled result beat changed");

endmodule

bind wasm_i32_stack_execution_unit wis_checker u_wis_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_jump        (o_jump),
    .o_jump_offset (o_jump_offset),
    .o_top_value   (o_top_value),
    .o_stack_count (o_stack_count)
);
